// File: design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the interval set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int VAL_W   = 63;
    localparam int TOL_W   = 32;
    localparam int ACT_W   = 3;
    localparam int RIDX_W  = 6;
    localparam int IN_W    = 136;
    localparam int OUT_W   = 136;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1000000);

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_PQUERY = 3'd2,
        ACT_IQUERY = 3'd3,
        ACT_COLL   = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_READ   = 3'd6,
        ACT_NOP    = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_IVL = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_IDX = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BAD,
        S_SCAN_RD,
        S_SCAN_EV,
        S_CMP,
        S_PLAN,
        S_WRA,
        S_WRB,
        S_MV_RD,
        S_MV_WR,
        S_QRY_RD,
        S_QRY_C1,
        S_QRY_C2,
        S_RD_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_UP,
        SH_DOWN
    } shift_t;

    typedef struct packed {
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] lo;
    } ent_t;

    typedef struct packed {
        logic ab;
        logic ba;
        logic near;
    } cmp_res_t;

endpackage

// File: design/ist_mem.sv
// ----------------------------------------------------------------------------
// ist_mem
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ist_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 126,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/ist_cmp.sv
// ----------------------------------------------------------------------------
// ist_cmp
// Shared tolerance comparator: a above b, b above a, a near b.
// ----------------------------------------------------------------------------
module ist_cmp (
    input  logic [ist_pkg::VAL_W-1:0] a,
    input  logic [ist_pkg::VAL_W-1:0] b,
    input  logic [ist_pkg::TOL_W-1:0] tol,
    output ist_pkg::cmp_res_t         res
);
    import ist_pkg::*;

    logic [VAL_W:0] a_x;
    logic [VAL_W:0] b_x;
    logic [VAL_W:0] t_x;
    logic [VAL_W:0] diff;

    assign a_x  = {1'b0, a};
    assign b_x  = {1'b0, b};
    assign t_x  = (VAL_W + 1)'(tol);
    assign diff = (a >= b) ? (a_x - b_x) : (b_x - a_x);

    assign res.ab   = a_x >= (b_x + t_x);
    assign res.ba   = b_x >= (a_x + t_x);
    assign res.near = diff <= t_x;

endmodule

// File: design/interval_set_table_unit.sv
// ----------------------------------------------------------------------------
// interval_set_table_unit
// Sorted table of disjoint nanosecond intervals with tolerant compares.
// ----------------------------------------------------------------------------
// One item is in flight at a time; s_axis_tready is high only while idle, and
// a finished result waits in the output register while the next item enters.
// Insert, delete and collision check scan the stored entries up to the
// affected range, compare the request with the first and last entries in it,
// and for insert and delete move the entries behind it. Point and interval
// queries read and compare every stored entry; clear and read do not scan.
// The work is serial because of the single read port of the entry memory and
// the one comparator that the scan, compare and query steps share.
module interval_set_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ist_pkg::TOL_W-1:0]  cfg_wr_data,    // tolerance_ns
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ist_pkg::IN_W-1:0]   s_axis_tdata,   // interval_start, interval_end, read_index
    input  logic [ist_pkg::ACT_W-1:0]  s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ist_pkg::OUT_W-1:0]  m_axis_tdata    // status, hit, entry_count, read_start, read_end
);
    import ist_pkg::*;

    state_t              state_reg, state_next;
    act_t                act_reg, act_next;
    logic [VAL_W-1:0]    st_reg, st_next;
    logic [VAL_W-1:0]    en_reg, en_next;
    logic [RIDX_W-1:0]   idx_reg, idx_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    i1_reg, i1_next;
    logic [CNT_W-1:0]    i2_reg, i2_next;
    logic                phase_reg, phase_next;
    ent_t                first_reg, first_next;
    ent_t                last_reg, last_next;
    logic                k0_reg, k0_next;
    logic                k1_reg, k1_next;
    cmp_res_t            k2_reg, k2_next;
    logic                k4_reg, k4_next;
    logic [1:0]          step_reg, step_next;
    logic                q1_reg, q1_next;
    shift_t              kind_reg, kind_next;
    logic                wa_en_reg, wa_en_next;
    logic [CNT_W-1:0]    wa_addr_reg, wa_addr_next;
    ent_t                wa_data_reg, wa_data_next;
    logic                wb_en_reg, wb_en_next;
    logic [CNT_W-1:0]    wb_addr_reg, wb_addr_next;
    ent_t                wb_data_reg, wb_data_next;
    logic [CNT_W-1:0]    src_reg, src_next;
    logic [CNT_W-1:0]    dst_reg, dst_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    status_t             status_reg, status_next;
    logic                hit_reg, hit_next;
    logic [VAL_W-1:0]    rs_reg, rs_next;
    logic [VAL_W-1:0]    re_reg, re_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    ent_t                mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    ent_t                mem_rdata;

    logic [VAL_W-1:0]    cmp_a;
    logic [VAL_W-1:0]    cmp_b;
    cmp_res_t            cmp;

    ist_mem #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(ent_t))
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ist_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .tol (tol_reg),
        .res (cmp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] j1;
        logic [CNT_W-1:0] j2;
        logic             fa;
        logic             fb;
        logic             full;
        logic [CNT_W-1:0] nn;

        state_next     = state_reg;
        act_next       = act_reg;
        st_next        = st_reg;
        en_next        = en_reg;
        idx_next       = idx_reg;
        tol_next       = cfg_wr_en ? cfg_wr_data : tol_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        k4_next        = k4_reg;
        step_next      = step_reg;
        q1_next        = q1_reg;
        kind_next      = kind_reg;
        wa_en_next     = wa_en_reg;
        wa_addr_next   = wa_addr_reg;
        wa_data_next   = wa_data_reg;
        wb_en_next     = wb_en_reg;
        wb_addr_next   = wb_addr_reg;
        wb_data_next   = wb_data_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        mem_we    = 1'b0;
        mem_waddr = src_reg[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = i_reg[IDX_W-1:0];
        cmp_a     = st_reg;
        cmp_b     = en_reg;

        d    = i2_reg - i1_reg;
        j1   = i1_reg;
        j2   = i2_reg;
        fa   = 1'b0;
        fb   = 1'b0;
        full = 1'b0;
        nn   = n_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next    = act_t'(s_axis_tuser);
                    st_next     = s_axis_tdata[VAL_W-1:0];
                    en_next     = s_axis_tdata[2*VAL_W-1:VAL_W];
                    idx_next    = s_axis_tdata[2*VAL_W+RIDX_W-1:2*VAL_W];
                    status_next = ST_OK;
                    hit_next    = 1'b0;
                    rs_next     = '0;
                    re_next     = '0;
                    i_next      = '0;
                    phase_next  = 1'b0;
                    step_next   = '0;
                    state_next  = S_BAD;
                end
            end

            S_BAD:
            begin
                unique case (act_reg)
                    ACT_INSERT, ACT_DELETE, ACT_COLL:
                    begin
                        if (cmp.ab)
                        begin
                            status_next = ST_BAD_IVL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    ACT_PQUERY, ACT_IQUERY:
                    begin
                        state_next = S_QRY_RD;
                    end
                    ACT_CLEAR:
                    begin
                        n_next     = '0;
                        state_next = S_DONE;
                    end
                    ACT_READ:
                    begin
                        if (CNT_W'(idx_reg) >= n_reg)
                        begin
                            status_next = ST_BAD_IDX;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = idx_reg[IDX_W-1:0];
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RD_WAIT:
            begin
                rs_next    = mem_rdata.lo;
                re_next    = mem_rdata.hi;
                state_next = S_DONE;
            end

            S_SCAN_RD:
            begin
                if (i_reg == n_reg)
                begin
                    if (!phase_reg)
                    begin
                        i1_next = n_reg;
                    end
                    i2_next    = n_reg;
                    state_next = S_CMP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV:
            begin
                if (!phase_reg)
                begin
                    cmp_a = st_reg;
                    cmp_b = mem_rdata.hi;
                    if (cmp.ab)
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        i1_next    = i_reg;
                        first_next = mem_rdata;
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    cmp_a = en_reg;
                    cmp_b = mem_rdata.lo;
                    if (cmp.ab)
                    begin
                        last_next  = mem_rdata;
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        if (act_reg == ACT_INSERT && cmp.near)
                        begin
                            last_next = mem_rdata;
                            i2_next   = i_reg + CNT_W'(1);
                        end
                        else
                        begin
                            i2_next = i_reg;
                        end
                        state_next = S_CMP;
                    end
                end
            end

            S_CMP:
            begin
                unique case (step_reg)
                    2'd0:
                    begin
                        cmp_a   = st_reg;
                        cmp_b   = first_reg.lo;
                        k0_next = cmp.ab;
                    end
                    2'd1:
                    begin
                        cmp_a   = first_reg.hi;
                        cmp_b   = st_reg;
                        k1_next = cmp.ab;
                    end
                    2'd2:
                    begin
                        cmp_a   = last_reg.hi;
                        cmp_b   = en_reg;
                        k2_next = cmp;
                    end
                    default:
                    begin
                        cmp_a      = en_reg;
                        cmp_b      = last_reg.lo;
                        k4_next    = cmp.ab;
                        state_next = S_PLAN;
                    end
                endcase
                step_next = step_reg + 2'd1;
            end

            S_PLAN:
            begin
                kind_next  = SH_NONE;
                wa_en_next = 1'b0;
                wb_en_next = 1'b0;
                if (act_reg == ACT_INSERT)
                begin
                    if (d == '0)
                    begin
                        if (n_reg == CNT_W'(ENTRIES))
                        begin
                            full = 1'b1;
                        end
                        else
                        begin
                            kind_next    = SH_UP;
                            src_next     = n_reg - CNT_W'(1);
                            dst_next     = n_reg;
                            cnt_next     = n_reg - i1_reg;
                            wa_en_next   = 1'b1;
                            wa_addr_next = i1_reg;
                            wa_data_next = '{hi: en_reg, lo: st_reg};
                            nn           = n_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        wa_en_next      = 1'b1;
                        wa_addr_next    = i1_reg;
                        wa_data_next.lo = k0_reg ? first_reg.lo : st_reg;
                        wa_data_next.hi = (k2_reg.ab || k2_reg.near) ? last_reg.hi : en_reg;
                        kind_next       = SH_DOWN;
                        src_next        = i2_reg;
                        dst_next        = i1_reg + CNT_W'(1);
                        cnt_next        = n_reg - i2_reg;
                        nn              = n_reg - (d - CNT_W'(1));
                    end
                end
                else if (d == CNT_W'(1))
                begin
                    if (k0_reg && k2_reg.ab)
                    begin
                        if (n_reg == CNT_W'(ENTRIES))
                        begin
                            full = 1'b1;
                        end
                        else
                        begin
                            kind_next    = SH_UP;
                            src_next     = n_reg - CNT_W'(1);
                            dst_next     = n_reg;
                            cnt_next     = n_reg - i1_reg;
                            wa_en_next   = 1'b1;
                            wa_addr_next = i1_reg;
                            wa_data_next = '{hi: st_reg, lo: first_reg.lo};
                            wb_en_next   = 1'b1;
                            wb_addr_next = i1_reg + CNT_W'(1);
                            wb_data_next = '{hi: first_reg.hi, lo: en_reg};
                            nn           = n_reg + CNT_W'(1);
                        end
                    end
                    else if (k0_reg && (k2_reg.ba || k2_reg.near))
                    begin
                        wa_en_next   = 1'b1;
                        wa_addr_next = i1_reg;
                        wa_data_next = '{hi: st_reg, lo: first_reg.lo};
                    end
                    else if (k4_reg && k2_reg.ab)
                    begin
                        wa_en_next   = 1'b1;
                        wa_addr_next = i1_reg;
                        wa_data_next = '{hi: first_reg.hi, lo: en_reg};
                    end
                    else
                    begin
                        kind_next = SH_DOWN;
                        src_next  = i1_reg + CNT_W'(1);
                        dst_next  = i1_reg;
                        cnt_next  = n_reg - i1_reg - CNT_W'(1);
                        nn        = n_reg - CNT_W'(1);
                    end
                end
                else if (d != '0)
                begin
                    fa = k0_reg && k1_reg;
                    fb = k2_reg.ab && k4_reg;
                    j1 = i1_reg + CNT_W'(fa);
                    j2 = i2_reg - CNT_W'(fb);
                    wa_en_next   = fa;
                    wa_addr_next = i1_reg;
                    wa_data_next = '{hi: st_reg, lo: first_reg.lo};
                    wb_en_next   = fb;
                    wb_addr_next = i2_reg - CNT_W'(1);
                    wb_data_next = '{hi: last_reg.hi, lo: en_reg};
                    if (j2 != j1)
                    begin
                        kind_next = SH_DOWN;
                        src_next  = j2;
                        dst_next  = j1;
                        cnt_next  = n_reg - j2;
                        nn        = n_reg - (j2 - j1);
                    end
                end

                if (act_reg == ACT_COLL)
                begin
                    hit_next = full || (nn != n_reg)
                        || (wa_en_next && (wa_data_next != first_reg))
                        || (wb_en_next && (wb_data_next != last_reg));
                    state_next = S_DONE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    n_next     = nn;
                    state_next = (kind_next == SH_UP) ? S_MV_RD : S_WRA;
                end
            end

            S_WRA:
            begin
                mem_we     = wa_en_reg;
                mem_waddr  = wa_addr_reg[IDX_W-1:0];
                mem_wdata  = wa_data_reg;
                state_next = S_WRB;
            end

            S_WRB:
            begin
                mem_we     = wb_en_reg;
                mem_waddr  = wb_addr_reg[IDX_W-1:0];
                mem_wdata  = wb_data_reg;
                state_next = (kind_reg == SH_DOWN) ? S_MV_RD : S_DONE;
            end

            S_MV_RD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (kind_reg == SH_UP) ? S_WRA : S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = src_reg[IDX_W-1:0];
                    state_next = S_MV_WR;
                end
            end

            S_MV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                if (kind_reg == SH_UP)
                begin
                    src_next = src_reg - CNT_W'(1);
                    dst_next = dst_reg - CNT_W'(1);
                end
                else
                begin
                    src_next = src_reg + CNT_W'(1);
                    dst_next = dst_reg + CNT_W'(1);
                end
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = S_MV_RD;
            end

            S_QRY_RD:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_QRY_C1;
                end
            end

            S_QRY_C1:
            begin
                cmp_a      = st_reg;
                cmp_b      = mem_rdata.lo;
                q1_next    = cmp.ab;
                state_next = S_QRY_C2;
            end

            S_QRY_C2:
            begin
                cmp_a = mem_rdata.hi;
                cmp_b = (act_reg == ACT_PQUERY) ? st_reg : en_reg;
                if (q1_reg && cmp.ab)
                begin
                    hit_next = 1'b1;
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = S_QRY_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {re_reg, rs_reg, n_reg, hit_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_NOP;
            st_reg        <= '0;
            en_reg        <= '0;
            idx_reg       <= '0;
            tol_reg       <= TOL_RESET;
            n_reg         <= '0;
            i_reg         <= '0;
            i1_reg        <= '0;
            i2_reg        <= '0;
            phase_reg     <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            k0_reg        <= 1'b0;
            k1_reg        <= 1'b0;
            k2_reg        <= '0;
            k4_reg        <= 1'b0;
            step_reg      <= '0;
            q1_reg        <= 1'b0;
            kind_reg      <= SH_NONE;
            wa_en_reg     <= 1'b0;
            wa_addr_reg   <= '0;
            wa_data_reg   <= '0;
            wb_en_reg     <= 1'b0;
            wb_addr_reg   <= '0;
            wb_data_reg   <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            cnt_reg       <= '0;
            status_reg    <= ST_OK;
            hit_reg       <= 1'b0;
            rs_reg        <= '0;
            re_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            st_reg        <= st_next;
            en_reg        <= en_next;
            idx_reg       <= idx_next;
            tol_reg       <= tol_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            i1_reg        <= i1_next;
            i2_reg        <= i2_next;
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            k0_reg        <= k0_next;
            k1_reg        <= k1_next;
            k2_reg        <= k2_next;
            k4_reg        <= k4_next;
            step_reg      <= step_next;
            q1_reg        <= q1_next;
            kind_reg      <= kind_next;
            wa_en_reg     <= wa_en_next;
            wa_addr_reg   <= wa_addr_next;
            wa_data_reg   <= wa_data_next;
            wb_en_reg     <= wb_en_next;
            wb_addr_reg   <= wb_addr_next;
            wb_data_reg   <= wb_data_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            status_reg    <= status_next;
            hit_reg       <= hit_next;
            rs_reg        <= rs_next;
            re_reg        <= re_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != $past(n_reg)) |-> ($past(state_reg) == S_PLAN || $past(state_reg) == S_BAD))
        else $error("entry count changed outside commit");

    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MV_WR) |-> ($past(state_reg) == S_MV_RD))
        else $error("move write without read");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Interval set table testbench
// Drives inserts, deletes, queries, collision checks, clears and reads into
// the table over the input stream, with random gaps on both sides. A
// scoreboard keeps its own copy of the table and the tolerance, predicts each
// response, and checks every response on the output stream field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    localparam longint unsigned VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [VAL_W-1:0] rd_end;
        logic [VAL_W-1:0] rd_start;
        logic [6:0]       count;
        logic             hit;
        logic [1:0]       status;
    } resp_t;

    class interval_scoreboard;
        longint unsigned tol;
        longint unsigned starts[ENTRIES];
        longint unsigned ends[ENTRIES];
        int count;
        longint unsigned ws[ENTRIES + 1];
        longint unsigned we[ENTRIES + 1];
        int wn;
        resp_t expected_q[$];
        int full_seen;
        int hit_seen;
        int badidx_seen;

        function new();
            tol = 64'(TOL_RESET);
            count = 0;
            full_seen = 0;
            hit_seen = 0;
            badidx_seen = 0;
            foreach (starts[i])
            begin
                starts[i] = 0;
                ends[i] = 0;
            end
        endfunction

        function bit above(longint unsigned a, longint unsigned b);
            return a >= b + tol;
        endfunction

        function bit near(longint unsigned a, longint unsigned b);
            return (a >= b) ? (a - b <= tol) : (b - a <= tol);
        endfunction

        function bit at_least(longint unsigned a, longint unsigned b);
            return above(a, b) || near(a, b);
        endfunction

        function void load();
            for (int i = 0; i < ENTRIES; i++)
            begin
                ws[i] = starts[i];
                we[i] = ends[i];
            end
            wn = count;
        endfunction

        function void erase(int a, int b);
            for (int i = a; i < wn - (b - a); i++)
            begin
                ws[i] = ws[i + b - a];
                we[i] = we[i + b - a];
            end
            wn -= b - a;
        endfunction

        function void open_at(int at);
            for (int i = wn; i > at; i--)
            begin
                ws[i] = ws[i - 1];
                we[i] = we[i - 1];
            end
            wn++;
        endfunction

        function void merge_in(longint unsigned st, longint unsigned en);
            int i1;
            int i2;
            i1 = 0;
            while (i1 < wn && above(st, we[i1])) i1++;
            i2 = i1;
            while (i2 < wn && above(en, ws[i2])) i2++;
            if (i2 < wn && near(en, ws[i2])) i2++;
            if (i1 == i2)
            begin
                open_at(i1);
                ws[i1] = st;
                we[i1] = en;
            end
            else
            begin
                if (above(st, ws[i1])) st = ws[i1];
                if (at_least(we[i2 - 1], en)) en = we[i2 - 1];
                ws[i1] = st;
                we[i1] = en;
                erase(i1 + 1, i2);
            end
        endfunction

        function void subtract(longint unsigned st, longint unsigned en);
            int i1;
            int i2;
            i1 = 0;
            while (i1 < wn && above(st, we[i1])) i1++;
            i2 = i1;
            while (i2 < wn && above(en, ws[i2])) i2++;
            if (i2 == i1 + 1)
            begin
                if (above(st, ws[i1]) && above(we[i1], en))
                begin
                    open_at(i1);
                    we[i1] = st;
                    ws[i1 + 1] = en;
                end
                else if (above(st, ws[i1]) && at_least(en, we[i1]))
                    we[i1] = st;
                else if (above(en, ws[i1]) && above(we[i1], en))
                    ws[i1] = en;
                else
                    erase(i1, i1 + 1);
            end
            else if (i2 >= i1 + 2)
            begin
                if (above(st, ws[i1]) && above(we[i1], st))
                begin
                    we[i1] = st;
                    i1++;
                end
                if (above(we[i2 - 1], en) && above(en, ws[i2 - 1]))
                begin
                    ws[i2 - 1] = en;
                    i2--;
                end
                if (i2 >= i1) erase(i1, i2);
            end
        endfunction

        function void commit(ref resp_t r);
            if (wn > ENTRIES)
            begin
                r.status = ST_FULL;
                full_seen++;
                return;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                starts[i] = ws[i];
                ends[i] = we[i];
            end
            count = wn;
        endfunction

        function void note(act_t act, longint unsigned st, longint unsigned en, int idx);
            resp_t r;
            bit bad;
            r = '0;
            bad = above(st, en);
            case (act)
                ACT_INSERT, ACT_DELETE:
                begin
                    if (bad)
                        r.status = ST_BAD_IVL;
                    else
                    begin
                        load();
                        if (act == ACT_INSERT) merge_in(st, en);
                        else subtract(st, en);
                        commit(r);
                    end
                end
                ACT_PQUERY:
                    for (int i = 0; i < count; i++)
                        if (above(st, starts[i]) && above(ends[i], st)) r.hit = 1;
                ACT_IQUERY:
                    for (int i = 0; i < count; i++)
                        if (above(st, starts[i]) && above(ends[i], en)) r.hit = 1;
                ACT_COLL:
                begin
                    if (bad)
                        r.status = ST_BAD_IVL;
                    else
                    begin
                        load();
                        subtract(st, en);
                        if (wn != count) r.hit = 1;
                        else
                            for (int i = 0; i < wn; i++)
                                if (ws[i] != starts[i] || we[i] != ends[i]) r.hit = 1;
                    end
                end
                ACT_CLEAR:
                    count = 0;
                ACT_READ:
                begin
                    if (idx >= count)
                    begin
                        r.status = ST_BAD_IDX;
                        badidx_seen++;
                    end
                    else
                    begin
                        r.rd_start = starts[idx][VAL_W-1:0];
                        r.rd_end = ends[idx][VAL_W-1:0];
                    end
                end
                default: ;
            endcase
            if (r.hit) hit_seen++;
            r.count = 7'(count);
            expected_q.push_back(r);
        endfunction

        function string check(resp_t got);
            resp_t e;
            string msg;
            if (expected_q.size() == 0)
                return "response with nothing expected";
            e = expected_q.pop_front();
            msg = "";
            if (got.status !== e.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.hit !== e.hit)
                msg = {msg, $sformatf(" hit %0d/%0d", got.hit, e.hit)};
            if (got.count !== e.count)
                msg = {msg, $sformatf(" count %0d/%0d", got.count, e.count)};
            if (got.rd_start !== e.rd_start)
                msg = {msg, $sformatf(" rd_start %0h/%0h", got.rd_start, e.rd_start)};
            if (got.rd_end !== e.rd_end)
                msg = {msg, $sformatf(" rd_end %0h/%0h", got.rd_end, e.rd_end)};
            return msg;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]  cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [ACT_W-1:0]  s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    interval_set_table_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    interval_scoreboard sb = new();
    int  errors = 0;
    int  cycles = 0;
    int  transfers = 0;
    int  responses = 0;
    int  tol_changes = 0;
    bit  gaps_on = 1'b1;

    always #2 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("mismatch at response %0d:%s", responses, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= gaps_on ? ($urandom_range(99) >= 12) : 1'b1;

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            responses++;
            msg = sb.check(resp_t'(m_axis_tdata));
            if (msg != "") report_mismatch(msg);
        end
    end

    task automatic send(act_t act, longint unsigned st, longint unsigned en, int idx);
        if (gaps_on && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {4'b0, 6'(idx), en[VAL_W-1:0], st[VAL_W-1:0]};
        do @(posedge clk); while (!s_axis_tready);
        sb.note(act, st & VMAX, en & VMAX, idx & 63);
        transfers++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.tol = 64'(v);
        tol_changes++;
    endtask

    function automatic longint unsigned rand63();
        return {$urandom, $urandom} & VMAX;
    endfunction

    task automatic random_phase(int n, longint unsigned base, longint unsigned step);
        longint unsigned st;
        longint unsigned en;
        longint unsigned tmp;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            st = base + longint'($urandom_range(400)) * step + $urandom_range(32'(step));
            en = st + longint'($urandom_range(30)) * step + $urandom_range(32'(step));
            if ($urandom_range(99) < 5)
            begin
                st = rand63();
                en = rand63();
                if (st > en && $urandom_range(3) != 0)
                begin
                    tmp = st;
                    st = en;
                    en = tmp;
                end
            end
            else if ($urandom_range(99) < 4)
            begin
                tmp = st;
                st = en + 2 * step + sb.tol;
                en = tmp;
            end
            pick = $urandom_range(99);
            if (pick < 36) send(ACT_INSERT, st, en, $urandom_range(63));
            else if (pick < 56) send(ACT_DELETE, st, en, $urandom_range(63));
            else if (pick < 66) send(ACT_PQUERY, st, en, $urandom_range(63));
            else if (pick < 76) send(ACT_IQUERY, st, en, $urandom_range(63));
            else if (pick < 87) send(ACT_COLL, st, en, $urandom_range(63));
            else if (pick < 97)
                send(ACT_READ, st, en,
                     $urandom_range(1) ? $urandom_range(sb.count + 1) : $urandom_range(63));
            else if (pick < 99) send(ACT_CLEAR, st, en, $urandom_range(63));
            else send(ACT_NOP, st, en, $urandom_range(63));
        end
    endtask

    initial
    begin
        int k;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed checks at the reset tolerance
        send(ACT_READ,   0, 0, 0);
        send(ACT_PQUERY, 5, 0, 0);
        send(ACT_INSERT, 0, 5000000, 0);
        send(ACT_INSERT, 10000000, 5000000, 0);
        send(ACT_INSERT, 5500000, 8000000, 0);
        send(ACT_INSERT, 20000000, 30000000, 0);
        send(ACT_INSERT, VMAX - 10000000, VMAX, 0);
        send(ACT_INSERT, 0, 0, 0);
        send(ACT_READ,   0, 0, 0);
        send(ACT_READ,   0, 0, 2);
        send(ACT_READ,   0, 0, 63);
        send(ACT_PQUERY, 25000000, 0, 0);
        send(ACT_IQUERY, 21500000, 28000000, 0);
        send(ACT_IQUERY, 29000000, 21500000, 0);
        send(ACT_COLL,   40000000, 50000000, 0);
        send(ACT_COLL,   50000000, 40000000, 0);
        send(ACT_COLL,   24000000, 26000000, 0);
        send(ACT_DELETE, 24000000, 26000000, 0);
        send(ACT_DELETE, 28000000, 31000000, 0);
        send(ACT_DELETE, 0, 22000000, 0);
        send(ACT_DELETE, 9000000, 2000000, 0);
        send(ACT_NOP,    VMAX, VMAX, 63);
        send(ACT_READ,   0, 0, 1);
        send(ACT_CLEAR,  0, 0, 0);
        send(ACT_READ,   0, 0, 0);

        // fill the table to capacity with zero tolerance
        set_tolerance(0);
        for (int i = 0; i < 70; i++)
        begin
            k = (i * 37) % 70;
            send(ACT_INSERT, k * 8, k * 8 + 3, 0);
        end
        send(ACT_COLL,   8 * 9 + 1, 8 * 9 + 2, 0);
        send(ACT_DELETE, 8 * 9 + 1, 8 * 9 + 2, 0);
        send(ACT_INSERT, 8 * 9 + 2, 8 * 10 + 1, 0);
        send(ACT_DELETE, 8 * 9 + 1, 8 * 9 + 2, 0);
        send(ACT_READ,   0, 0, 63);
        send(ACT_DELETE, 100, 300, 0);

        random_phase(200, 0, 10);
        set_tolerance(TOL_RESET);
        gaps_on = 1'b0;
        random_phase(200, 0, 1000000);
        gaps_on = 1'b1;
        set_tolerance(32'hFFFF_FFFF);
        random_phase(180, VMAX - (64'd1 << 45), 64'd1 << 33);
        set_tolerance(37);
        random_phase(200, 64'd1 << 40, 50);
        set_tolerance($urandom);
        random_phase(200, rand63() >> 2, 64'(sb.tol) + 1);

        drain();
        repeat (300) @(negedge clk);
        while (sb.expected_q.size() != 0)
        begin
            void'(sb.expected_q.pop_front());
            report_mismatch(" expected response never arrived");
        end
        $display("covered %0d transfers, %0d responses, %0d tolerance writes",
                 transfers, responses, tol_changes);
        $display("table full %0d times, hits %0d, bad index %0d, mismatches %0d",
                 sb.full_seen, sb.hit_seen, sb.badidx_seen, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
